// ----- src/b64d_pkg.sv -----
// shared types, constants and the character classifier of the base64 decoder
// no dependencies
`default_nettype none

package b64d_pkg;

   localparam int CHAR_W    = 8;
   localparam int CLASS_W   = 7;
   localparam int GROUP_W   = 24;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [CLASS_W-1:0] CLASS_PAD  = 7'd64;
   localparam logic [CLASS_W-1:0] CLASS_SKIP = 7'd65;

   // one entry of the command queue: everything one input transfer emits
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [1:0]         nbytes;
      logic               err;
      logic               eom;
   } b64d_cmd_type;

   // 0-63 for an alphabet character, pad code, or skip code
   function automatic logic [CLASS_W-1:0] b64d_classify(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = 8'd0;
      priority if (c >= 8'h41 && c <= 8'h5a) begin
         d = c - 8'h41;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         d = c - 8'h61 + 8'd26;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
      end else if (c == 8'h2b) begin
         d = 8'd62;
      end else if (c == 8'h2f) begin
         d = 8'd63;
      end else if (c == 8'h3d) begin
         d = {1'b0, CLASS_PAD};
      end else begin
         d = {1'b0, CLASS_SKIP};
      end
      return d[CLASS_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/base64_decoder.sv -----
// top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back
`default_nettype none

// Streaming base64 decoder. One character enters per transfer on the req_
// side (tlast marks the last character of a message); results leave on the
// rsp_ side with tuser giving the kind (data byte, padding error, end of
// message) and tlast marking the final result caused by one input transfer.
// A character is taken every cycle while the four-entry command queue has
// room. Results leave at one per cycle from the output register while
// rsp_tready is high, so a full group gives three data results and an end
// of message adds one more. Input stalls only when the queue fills behind
// a stalled or busy output side. An accepted character's command passes
// through the queue memory and then the output register to the rsp_ side.
module base64_decoder
   import b64d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // input characters
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // end_of_message
   // decoded results
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] data_byte
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast    // last
);

   logic         push;
   b64d_cmd_type push_cmd;
   logic         q_full;
   logic         q_not_empty;
   logic         q_pop;
   b64d_cmd_type q_head;

   // classification and group assembly
   b64d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_char  (req_tdata),
      .in_eom   (req_tlast),
      .q_full   (q_full),
      .in_ready (req_tready),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // decouples character intake from result output
   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // result sequencing and output register
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- src/b64d_front.sv -----
// front end: classifies characters, gathers sextets into groups and issues commands
// depends on b64d_pkg
`default_nettype none

module b64d_front
   import b64d_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [CHAR_W-1:0] in_char,
   input  wire logic              in_eom,
   input  wire logic              q_full,
   output logic                   in_ready,
   output logic                   push,
   output b64d_cmd_type           push_cmd
);

   logic [GROUP_W-1:0] acc_ff, acc_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [2:0]         pad_ff, pad_in;
   logic               fin_ff, fin_in;

   logic [CLASS_W-1:0] cls;
   logic [2:0]         pad_new;
   logic [GROUP_W-1:0] acc_new;
   logic               counted;
   logic               group_done;
   logic               accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign cls      = b64d_classify(in_char);
   assign counted  = !fin_ff && (cls <= CLASS_PAD);
   assign pad_new  = pad_ff + {2'd0, (cls == CLASS_PAD)};
   assign acc_new  = {acc_ff[GROUP_W-7:0], (cls == CLASS_PAD) ? 6'd0 : cls[5:0]};
   assign group_done = counted && (cnt_ff == 2'd3);

   always_comb begin
      push_cmd.group  = acc_new;
      push_cmd.err    = group_done && (pad_new > 3'd2);
      push_cmd.nbytes = 2'd0;
      if (group_done && (pad_new <= 3'd2)) begin
         push_cmd.nbytes = 2'd3 - pad_new[1:0];
      end
      push_cmd.eom    = in_eom;
      push = accept && (group_done || in_eom);
   end

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      fin_in = fin_ff;
      if (accept) begin
         if (in_eom) begin
            acc_in = '0;
            cnt_in = 2'd0;
            pad_in = 3'd0;
            fin_in = 1'b0;
         end else if (group_done) begin
            acc_in = '0;
            cnt_in = 2'd0;
            pad_in = 3'd0;
            fin_in = (pad_new != 3'd0);
         end else if (counted) begin
            acc_in = acc_new;
            cnt_in = cnt_ff + 2'd1;
            pad_in = pad_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= 2'd0;
         pad_ff <= 3'd0;
         fin_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
         fin_ff <= fin_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/b64d_queue.sv -----
// short command queue between front and back end
// depends on b64d_pkg
`default_nettype none

module b64d_queue
   import b64d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire b64d_cmd_type push_cmd,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output b64d_cmd_type      head
);

   b64d_cmd_type       mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/b64d_back.sv -----
// back end: turns queued commands into results, one per cycle unless stalled
// depends on b64d_pkg
`default_nettype none

module b64d_back
   import b64d_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_not_empty,
   input  wire b64d_cmd_type q_head,
   output logic              q_pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output logic [1:0]        out_kind,
   output logic [7:0]        out_byte,
   output logic              out_last
);

   logic       vld_ff, vld_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [1:0] idx_ff, idx_in;

   logic       load;
   logic [2:0] total;
   logic [1:0] kind_nx;
   logic [7:0] byte_nx;
   logic       last_nx;

   assign total = {1'b0, q_head.nbytes} + {2'd0, q_head.err} + {2'd0, q_head.eom};
   assign load  = q_not_empty && (!vld_ff || out_ready);
   assign last_nx = ({1'b0, idx_ff} == total - 3'd1);
   assign q_pop = load && last_nx;

   always_comb begin
      kind_nx = KIND_END;
      byte_nx = 8'd0;
      if (idx_ff < q_head.nbytes) begin
         kind_nx = KIND_DATA;
         unique case (idx_ff)
            2'd0:    byte_nx = q_head.group[23:16];
            2'd1:    byte_nx = q_head.group[15:8];
            default: byte_nx = q_head.group[7:0];
         endcase
      end else if (q_head.err && idx_ff == 2'd0) begin
         kind_nx = KIND_ERROR;
      end
   end

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (load) begin
         vld_in = 1'b1;
         idx_in = last_nx ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_nx;
         byte_ff <= byte_nx;
         last_ff <= last_nx;
      end
   end

   assign out_valid = vld_ff;
   assign out_kind  = kind_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
